>>> rtl/tsx_pkg.sv
package tsx_pkg;

    localparam int unsigned VarintMaxBytes = 10;
    localparam int unsigned QueueDepth     = 4;
    localparam int unsigned QueuePtrW      = $clog2(QueueDepth);

    localparam logic [7:0] NoWindow  = 8'hff;
    localparam logic [4:0] LeadClamp = 5'd31;

    // register indexes
    localparam logic [2:0] RegResumeCount    = 3'd0;
    localparam logic [2:0] RegResumeTime     = 3'd1;
    localparam logic [2:0] RegResumeBits     = 3'd2;
    localparam logic [2:0] RegResumeDelta    = 3'd3;
    localparam logic [2:0] RegResumeLeading  = 3'd4;
    localparam logic [2:0] RegResumeTrailing = 3'd5;

    typedef enum logic [1:0] {KIND_FIRST, KIND_SECOND, KIND_LATER} kind_t;
    typedef enum logic [2:0] {DOD_ZERO, DOD_14, DOD_17, DOD_20, DOD_64} dcls_t;
    typedef enum logic [1:0] {XOR_ZERO, XOR_REUSE, XOR_NEW} xcls_t;
    typedef enum logic [3:0] {
        PH_VARINT, PH_RAW, PH_DODP, PH_DODF, PH_XFLAG,
        PH_XCTL, PH_XLEAD, PH_XLEN, PH_XSIG
    } ph_t;

    // one classified sample, passed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [63:0] zz;
        logic [3:0]  nvb;
        logic [63:0] dod;
        dcls_t       dcls;
        xcls_t       xcls;
        logic [4:0]  xlead;
        logic [6:0]  sig;
        logic [63:0] val;
        logic [15:0] count;
    } desc_t;

    function automatic logic [6:0] clz64(input logic [63:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                n = 7'(63 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [6:0] ctz64(input logic [63:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 63; i >= 0; i--)
        begin
            if (x[i])
            begin
                n = 7'(i);
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/tsx_front.sv
module tsx_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [63:0]        sample_time,
    input  logic [63:0]        sample_bits,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output tsx_pkg::desc_t     desc
);

    logic [63:0] prev_time_reg, prev_bits_reg, prev_delta_reg;
    logic [7:0]  lead_reg;
    logic [5:0]  trail_reg;
    logic [15:0] total_reg;

    logic [63:0] delta, dod, dodm, vsrc, zz, x, xs;
    logic [6:0]  clz, tz, sig;
    logic [4:0]  lz;
    logic [3:0]  nvb;
    tsx_pkg::kind_t kind;
    tsx_pkg::dcls_t dcls;
    tsx_pkg::xcls_t xcls;
    logic        reuse;

    // classification of the incoming word
    always_comb
    begin
        delta = sample_time - prev_time_reg;
        dod   = delta - prev_delta_reg;
        dodm  = dod - 64'd1;
        if (total_reg == 16'd0)
            kind = tsx_pkg::KIND_FIRST;
        else if (total_reg == 16'd1)
            kind = tsx_pkg::KIND_SECOND;
        else
            kind = tsx_pkg::KIND_LATER;

        vsrc = (kind == tsx_pkg::KIND_FIRST) ? sample_time : delta;
        zz   = (vsrc << 1) ^ {64{vsrc[63]}};
        nvb  = 4'd1;
        for (int k = 1; k < tsx_pkg::VarintMaxBytes; k++)
        begin
            nvb = nvb + 4'((zz >> (7 * k)) != 64'd0);
        end

        // dod - 1 fits in n signed bits means dod lies in the n-bit class
        if (dod == 64'd0)
            dcls = tsx_pkg::DOD_ZERO;
        else if ((&dodm[63:13]) || !(|dodm[63:13]))
            dcls = tsx_pkg::DOD_14;
        else if ((&dodm[63:16]) || !(|dodm[63:16]))
            dcls = tsx_pkg::DOD_17;
        else if ((&dodm[63:19]) || !(|dodm[63:19]))
            dcls = tsx_pkg::DOD_20;
        else
            dcls = tsx_pkg::DOD_64;

        x   = sample_bits ^ prev_bits_reg;
        clz = tsx_pkg::clz64(x);
        tz  = tsx_pkg::ctz64(x);
        lz  = (clz > 7'd31) ? tsx_pkg::LeadClamp : clz[4:0];
        reuse = (lead_reg != tsx_pkg::NoWindow) && ({3'd0, lz} >= lead_reg)
                && (tz >= {1'b0, trail_reg});
        if (x == 64'd0)
        begin
            xcls = tsx_pkg::XOR_ZERO;
            sig  = 7'd64;
            xs   = 64'd0;
        end
        else if (reuse)
        begin
            xcls = tsx_pkg::XOR_REUSE;
            sig  = 7'd64 - {2'd0, lead_reg[4:0]} - {1'b0, trail_reg};
            xs   = x >> trail_reg;
        end
        else
        begin
            xcls = tsx_pkg::XOR_NEW;
            sig  = 7'd64 - {2'd0, lz} - tz;
            xs   = x >> tz[5:0];
        end

        desc.kind  = kind;
        desc.zz    = zz;
        desc.nvb   = nvb;
        desc.dod   = dod;
        desc.dcls  = dcls;
        desc.xcls  = xcls;
        desc.xlead = lz;
        desc.sig   = sig;
        desc.val   = (kind == tsx_pkg::KIND_FIRST) ? sample_bits : xs;
        desc.count = total_reg + 16'd1;
    end

    // encoder state, loaded by config writes or advanced per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg  <= 64'd0;
            prev_bits_reg  <= 64'd0;
            prev_delta_reg <= 64'd0;
            lead_reg       <= tsx_pkg::NoWindow;
            trail_reg      <= 6'd0;
            total_reg      <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsx_pkg::RegResumeCount:    total_reg      <= cfg_data[15:0];
                tsx_pkg::RegResumeTime:     prev_time_reg  <= cfg_data;
                tsx_pkg::RegResumeBits:     prev_bits_reg  <= cfg_data;
                tsx_pkg::RegResumeDelta:    prev_delta_reg <= cfg_data;
                tsx_pkg::RegResumeLeading:  lead_reg       <= cfg_data[7:0];
                tsx_pkg::RegResumeTrailing: trail_reg      <= cfg_data[5:0];
                default: ;
            endcase
        end
        else if (accept)
        begin
            prev_time_reg  <= sample_time;
            prev_bits_reg  <= sample_bits;
            prev_delta_reg <= (kind == tsx_pkg::KIND_FIRST) ? 64'd0 : delta;
            total_reg      <= total_reg + 16'd1;
            if ((kind != tsx_pkg::KIND_FIRST) && (xcls == tsx_pkg::XOR_NEW))
            begin
                lead_reg  <= {3'd0, lz};
                trail_reg <= tz[5:0];
            end
        end
    end

endmodule

>>> rtl/tsx_queue.sv
module tsx_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsx_pkg::desc_t  wdata,
    input  logic            pop,
    output tsx_pkg::desc_t  rdata,
    output logic            full,
    output logic            nonempty
);

    tsx_pkg::desc_t                   mem_reg [tsx_pkg::QueueDepth];
    logic [tsx_pkg::QueuePtrW-1:0]    wptr_reg, rptr_reg;
    logic [tsx_pkg::QueuePtrW:0]      cnt_reg;

    assign full     = (cnt_reg == (tsx_pkg::QueuePtrW+1)'(tsx_pkg::QueueDepth));
    assign nonempty = (cnt_reg != '0);
    assign rdata    = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> rtl/tsx_back.sv
module tsx_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tsx_pkg::desc_t  qdata,
    input  logic            qnonempty,
    output logic            qpop,
    output logic            empty,
    input  logic            pop,
    output logic [63:0]     piece_bits,
    output logic [6:0]      piece_len,
    output logic            last_piece,
    output logic [15:0]     count_after
);

    tsx_pkg::desc_t  d_reg;
    tsx_pkg::ph_t    ph_reg, ph_next;
    logic            busy_reg;
    logic [63:0]     z_reg;
    logic [3:0]      vrem_reg;
    logic            ovalid_reg;
    logic [63:0]     obits_reg;
    logic [6:0]      olen_reg;
    logic            olast_reg;
    logic [15:0]     ocnt_reg;

    logic [63:0] pbits, mask;
    logic [6:0]  plen;
    logic        plast, adv, ld;

    assign adv  = busy_reg && (!ovalid_reg || pop);
    assign ld   = qnonempty && (!busy_reg || (adv && plast));
    assign qpop = ld;

    // next phase
    always_comb
    begin
        ph_next = ph_reg;
        case (ph_reg)
            tsx_pkg::PH_VARINT:
                if (vrem_reg == 4'd1)
                    ph_next = (d_reg.kind == tsx_pkg::KIND_FIRST) ?
                              tsx_pkg::PH_RAW : tsx_pkg::PH_XFLAG;
            tsx_pkg::PH_RAW:   ph_next = tsx_pkg::PH_RAW;
            tsx_pkg::PH_DODP:
                ph_next = (d_reg.dcls == tsx_pkg::DOD_ZERO) ?
                          tsx_pkg::PH_XFLAG : tsx_pkg::PH_DODF;
            tsx_pkg::PH_DODF:  ph_next = tsx_pkg::PH_XFLAG;
            tsx_pkg::PH_XFLAG: ph_next = tsx_pkg::PH_XCTL;
            tsx_pkg::PH_XCTL:
                ph_next = (d_reg.xcls == tsx_pkg::XOR_REUSE) ?
                          tsx_pkg::PH_XSIG : tsx_pkg::PH_XLEAD;
            tsx_pkg::PH_XLEAD: ph_next = tsx_pkg::PH_XLEN;
            tsx_pkg::PH_XLEN:  ph_next = tsx_pkg::PH_XSIG;
            tsx_pkg::PH_XSIG:  ph_next = tsx_pkg::PH_XSIG;
            default:           ph_next = tsx_pkg::PH_XSIG;
        endcase
    end

    // piece for the current phase
    always_comb
    begin
        pbits = 64'd0;
        plen  = 7'd1;
        plast = 1'b0;
        case (ph_reg)
            tsx_pkg::PH_VARINT:
            begin
                plen  = 7'd8;
                pbits = (vrem_reg == 4'd1) ? {56'd0, z_reg[7:0]}
                                           : {56'd0, 1'b1, z_reg[6:0]};
            end
            tsx_pkg::PH_RAW:
            begin
                plen  = 7'd64;
                pbits = d_reg.val;
                plast = 1'b1;
            end
            tsx_pkg::PH_DODP:
                case (d_reg.dcls)
                    tsx_pkg::DOD_ZERO: begin pbits = 64'h0; plen = 7'd1; end
                    tsx_pkg::DOD_14:   begin pbits = 64'h2; plen = 7'd2; end
                    tsx_pkg::DOD_17:   begin pbits = 64'h6; plen = 7'd3; end
                    tsx_pkg::DOD_20:   begin pbits = 64'he; plen = 7'd4; end
                    default:           begin pbits = 64'hf; plen = 7'd4; end
                endcase
            tsx_pkg::PH_DODF:
            begin
                pbits = d_reg.dod;
                case (d_reg.dcls)
                    tsx_pkg::DOD_14: plen = 7'd14;
                    tsx_pkg::DOD_17: plen = 7'd17;
                    tsx_pkg::DOD_20: plen = 7'd20;
                    default:         plen = 7'd64;
                endcase
            end
            tsx_pkg::PH_XFLAG:
            begin
                pbits = {63'd0, d_reg.xcls != tsx_pkg::XOR_ZERO};
                plast = (d_reg.xcls == tsx_pkg::XOR_ZERO);
            end
            tsx_pkg::PH_XCTL:
                pbits = {63'd0, d_reg.xcls == tsx_pkg::XOR_NEW};
            tsx_pkg::PH_XLEAD:
            begin
                pbits = {59'd0, d_reg.xlead};
                plen  = 7'd5;
            end
            tsx_pkg::PH_XLEN:
            begin
                pbits = {58'd0, d_reg.sig[5:0]};
                plen  = 7'd6;
            end
            tsx_pkg::PH_XSIG:
            begin
                pbits = d_reg.val;
                plen  = d_reg.sig;
                plast = 1'b1;
            end
            default: ;
        endcase
        mask = (plen == 7'd64) ? {64{1'b1}} : ((64'd1 << plen[5:0]) - 64'd1);
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            ph_reg     <= tsx_pkg::PH_VARINT;
            vrem_reg   <= 4'd0;
        end
        else
        begin
            if (adv)
                ovalid_reg <= 1'b1;
            else if (pop)
                ovalid_reg <= 1'b0;

            if (ld)
            begin
                busy_reg <= 1'b1;
                vrem_reg <= qdata.nvb;
                ph_reg   <= (qdata.kind == tsx_pkg::KIND_LATER) ?
                            tsx_pkg::PH_DODP : tsx_pkg::PH_VARINT;
            end
            else if (adv)
            begin
                if (plast)
                    busy_reg <= 1'b0;
                ph_reg   <= ph_next;
                vrem_reg <= vrem_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            d_reg <= qdata;
            z_reg <= qdata.zz;
        end
        else if (adv)
        begin
            z_reg <= z_reg >> 7;
        end
        if (adv)
        begin
            obits_reg <= pbits & mask;
            olen_reg  <= plen;
            olast_reg <= plast;
            ocnt_reg  <= d_reg.count;
        end
    end

    assign empty       = !ovalid_reg;
    assign piece_bits  = obits_reg;
    assign piece_len   = olen_reg;
    assign last_piece  = olast_reg;
    assign count_after = ocnt_reg;

endmodule

>>> rtl/time_series_xor_sample_encoder_top.sv
// With the queue and back idle, a sample passes the queue entry, the back's descriptor
// register and the output register before its first piece appears; behind queued
// samples it waits for their pieces to drain. Throughput: one piece per cycle from the
// back sequencer while the receiver pops; a sample has 2 to 15 pieces, and an idle back loads it first.
// The four-entry descriptor queue lets the front take samples while pieces drain.
// Reset (rst_n low, asynchronous) empties the queue and output and restores the
// encoder state to its reset values.
module time_series_xor_sample_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] sample_time,
    input  logic [63:0] sample_bits,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] piece_bits,
    output logic [6:0]  piece_len,
    output logic        last_piece,
    output logic [15:0] count_after,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    tsx_pkg::desc_t fdesc, qdesc;
    logic           qfull, qnonempty, qpop, accept;

    assign cfg_ready = 1'b1;
    assign full      = qfull;
    assign accept    = push && !qfull;

    tsx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample_time (sample_time),
        .sample_bits (sample_bits),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .desc        (fdesc)
    );

    tsx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .wdata    (fdesc),
        .pop      (qpop),
        .rdata    (qdesc),
        .full     (qfull),
        .nonempty (qnonempty)
    );

    tsx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .qdata       (qdesc),
        .qnonempty   (qnonempty),
        .qpop        (qpop),
        .empty       (empty),
        .pop         (pop),
        .piece_bits  (piece_bits),
        .piece_len   (piece_len),
        .last_piece  (last_piece),
        .count_after (count_after)
    );

endmodule

>>> rtl/tsx_checker.sv
module tsx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [63:0] piece_bits,
    input logic [6:0]  piece_len,
    input logic        last_piece,
    input logic [15:0] count_after
);

    // a shown word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(piece_bits) && $stable(piece_len)))
        else $error("output word changed while stalled");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (piece_len != 7'd0 && piece_len <= 7'd64))
        else $error("piece length out of range");

    a_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && piece_len < 7'd64) |-> ((piece_bits >> piece_len[5:0]) == 64'd0))
        else $error("bits set above piece length");

    // pieces of one sample carry one count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_piece) |=> (empty || count_after == $past(count_after)))
        else $error("count changed inside a sample");

endmodule

bind time_series_xor_sample_encoder_top tsx_checker u_tsx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .piece_bits  (piece_bits),
    .piece_len   (piece_len),
    .last_piece  (last_piece),
    .count_after (count_after)
);

>>> sim/time_series_xor_sample_encoder_top_test.sv
`timescale 1ns / 100ps

module time_series_xor_sample_encoder_top_test;

    localparam logic [2:0] RegSpare   = 3'd7;
    localparam int         IdleLimit  = 4000;
    localparam int         HoldCycles = 400;
    localparam int         DrainWait  = 20;

    typedef struct {
        logic [63:0] stamp;
        logic [63:0] bits;
    } sample_t;

    typedef struct {
        logic [63:0] bits;
        logic [6:0]  len;
        logic        last;
        logic [15:0] count;
    } piece_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [63:0] sample_time;
    logic [63:0] sample_bits;
    logic        empty;
    logic        pop;
    logic [63:0] piece_bits;
    logic [6:0]  piece_len;
    logic        last_piece;
    logic [15:0] count_after;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // encoder state mirror
    logic [63:0] enc_time;
    logic [63:0] enc_bits;
    logic [63:0] enc_delta;
    logic [7:0]  enc_lead;
    logic [5:0]  enc_trail;
    logic [15:0] enc_count;

    sample_t pending_samples[$];
    piece_t  expected_pieces[$];
    piece_t  new_pieces[$];

    int n_queued;
    int n_taken;
    int n_errors;
    int idle_cycles;
    int send_gap;
    int pop_gap;
    int hold_left;
    bit hold_req;
    bit push_taken;

    time_series_xor_sample_encoder_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_time (sample_time),
        .sample_bits (sample_bits),
        .empty       (empty),
        .pop         (pop),
        .piece_bits  (piece_bits),
        .piece_len   (piece_len),
        .last_piece  (last_piece),
        .count_after (count_after),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic add_piece(input logic [63:0] bits, input int len);
        piece_t p;
        p.bits  = (len >= 64) ? bits : (bits & ((64'd1 << len) - 64'd1));
        p.len   = 7'(len);
        p.last  = 1'b0;
        p.count = '0;
        new_pieces.push_back(p);
    endtask

    task automatic add_varint(input logic [63:0] v);
        logic [63:0] z;
        int n;
        z = (v << 1) ^ {64{v[63]}};
        n = 0;
        while (z >= 64'h80 && n < tsx_pkg::VarintMaxBytes - 1)
        begin
            add_piece((z & 64'h7f) | 64'h80, 8);
            z = z >> 7;
            n++;
        end
        add_piece(z & 64'hff, 8);
    endtask

    function automatic bit dod_fits(input logic [63:0] d, input int n);
        longint sv;
        longint half;
        sv   = $signed(d);
        half = longint'(1) << (n - 1);
        return sv >= -(half - 1) && sv <= half;
    endfunction

    task automatic add_xor_code(input logic [63:0] v);
        logic [63:0] x;
        int lz;
        int tz;
        int sig;
        x = v ^ enc_bits;
        if (x == 0)
        begin
            add_piece(64'd0, 1);
            return;
        end
        add_piece(64'd1, 1);
        lz = 0;
        while (lz < 64 && !x[63 - lz])
        begin
            lz++;
        end
        tz = 0;
        while (tz < 64 && !x[tz])
        begin
            tz++;
        end
        if (lz > 31)
        begin
            lz = 31;
        end
        if (enc_lead != tsx_pkg::NoWindow && lz >= enc_lead && tz >= enc_trail)
        begin
            add_piece(64'd0, 1);
            sig = 64 - enc_lead - enc_trail;
            add_piece(x >> enc_trail, sig);
        end
        else
        begin
            enc_lead  = 8'(lz);
            enc_trail = 6'(tz);
            add_piece(64'd1, 1);
            add_piece(64'(lz), 5);
            sig = 64 - lz - tz;
            add_piece(64'(sig) & 64'h3f, 6);
            add_piece(x >> tz, sig);
        end
    endtask

    // work out the pieces of one accepted sample
    task automatic encode_sample(input logic [63:0] t, input logic [63:0] v);
        logic [63:0] delta;
        logic [63:0] dod;
        delta = '0;
        new_pieces.delete();
        if (enc_count == 0)
        begin
            add_varint(t);
            add_piece(v, 64);
        end
        else if (enc_count == 1)
        begin
            delta = t - enc_time;
            add_varint(delta);
            add_xor_code(v);
        end
        else
        begin
            delta = t - enc_time;
            dod   = delta - enc_delta;
            if (dod == 0)
            begin
                add_piece(64'd0, 1);
            end
            else if (dod_fits(dod, 14))
            begin
                add_piece(64'h02, 2);
                add_piece(dod, 14);
            end
            else if (dod_fits(dod, 17))
            begin
                add_piece(64'h06, 3);
                add_piece(dod, 17);
            end
            else if (dod_fits(dod, 20))
            begin
                add_piece(64'h0e, 4);
                add_piece(dod, 20);
            end
            else
            begin
                add_piece(64'h0f, 4);
                add_piece(dod, 64);
            end
            add_xor_code(v);
        end
        enc_time  = t;
        enc_bits  = v;
        enc_delta = delta;
        enc_count = enc_count + 16'd1;
        foreach (new_pieces[k])
        begin
            new_pieces[k].last  = (k == new_pieces.size() - 1);
            new_pieces[k].count = enc_count;
            expected_pieces.push_back(new_pieces[k]);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // input side: accept, predict
    always @(posedge clk)
    begin
        push_taken = 1'b0;
        if (rst_n && push && !full)
        begin
            encode_sample(sample_time, sample_bits);
            n_taken++;
            push_taken = 1'b1;
        end
    end

    // result side: compare each accepted piece
    always @(posedge clk)
    begin
        piece_t w;
        if (rst_n && pop && !empty)
        begin
            if (expected_pieces.size() == 0)
            begin
                report_mismatch("unexpected word", piece_bits, '0);
            end
            else
            begin
                w = expected_pieces.pop_front();
                if (piece_bits !== w.bits)
                    report_mismatch("piece_bits", piece_bits, w.bits);
                if (piece_len !== w.len)
                    report_mismatch("piece_len", 64'(piece_len), 64'(w.len));
                if (last_piece !== w.last)
                    report_mismatch("last_piece", 64'(last_piece), 64'(w.last));
                if (count_after !== w.count)
                    report_mismatch("count_after", 64'(count_after), 64'(w.count));
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // sender
    always @(negedge clk)
    begin
        logic next_push;
        sample_t s;
        next_push = push;
        if (!rst_n)
        begin
            next_push = 1'b0;
        end
        else if (!push || push_taken)
        begin
            next_push = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (pending_samples.size() > 0)
            begin
                s = pending_samples.pop_front();
                sample_time <= s.stamp;
                sample_bits <= s.bits;
                next_push = 1'b1;
                send_gap = pick_gap();
            end
        end
        push <= next_push;
    end

    // receiver, with one long hold-off on request
    always @(negedge clk)
    begin
        logic next_pop;
        next_pop = 1'b0;
        if (hold_left > 0)
        begin
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HoldCycles;
        end
        else if (pop_gap > 0)
        begin
            pop_gap--;
        end
        else
        begin
            next_pop = rst_n;
            pop_gap = ($urandom_range(3) == 0) ? pick_gap() : 0;
        end
        pop <= next_pop;
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout: no handshake for %0d cycles", IdleLimit);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tsx_pkg::RegResumeCount:    enc_count = data[15:0];
            tsx_pkg::RegResumeTime:     enc_time  = data;
            tsx_pkg::RegResumeBits:     enc_bits  = data;
            tsx_pkg::RegResumeDelta:    enc_delta = data;
            tsx_pkg::RegResumeLeading:  enc_lead  = data[7:0];
            tsx_pkg::RegResumeTrailing: enc_trail = data[5:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(input logic [63:0] t, input logic [63:0] v);
        sample_t s;
        s.stamp = t;
        s.bits  = v;
        pending_samples.push_back(s);
        n_queued++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (n_taken != n_queued || expected_pieces.size() != 0);
        repeat (DrainWait) @(negedge clk);
    endtask

    // mostly regular series with jittered timing and nearby values
    task automatic queue_series(input int n);
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] v;
        logic [63:0] dod;
        logic [63:0] flip;
        int sh;
        t = enc_time;
        d = enc_delta;
        v = enc_bits;
        repeat (n)
        begin
            case ($urandom_range(9))
                0, 1, 2: dod = '0;
                3, 4:    dod = 64'($signed($urandom_range(16382)) - 8191);
                5:       dod = 64'($signed($urandom_range(131070)) - 65535);
                6:       dod = 64'($signed($urandom_range(1048574)) - 524287);
                7:       dod = {$urandom, $urandom};
                8:       dod = 64'($signed($urandom_range(4)) - 2);
                default: dod = 64'($signed($urandom_range(600000)) - 300000);
            endcase
            d = d + dod;
            t = t + d;
            case ($urandom_range(9))
                0, 1:    flip = '0;
                2:       flip = {$urandom, $urandom};
                3:       flip = 64'd1 << $urandom_range(63);
                default:
                begin
                    sh   = $urandom_range(52);
                    flip = (64'($urandom_range(2047)) << sh);
                end
            endcase
            v = v ^ flip;
            if ($urandom_range(19) == 0)
            begin
                t = {$urandom, $urandom};
            end
            queue_sample(t, v);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        sample_time = '0;
        sample_bits = '0;
        cfg_valid   = 1'b0;
        cfg_index   = tsx_pkg::RegResumeCount;
        cfg_data    = '0;
        enc_time    = '0;
        enc_bits    = '0;
        enc_delta   = '0;
        enc_lead    = tsx_pkg::NoWindow;
        enc_trail   = '0;
        enc_count   = '0;
        n_queued    = 0;
        n_taken     = 0;
        n_errors    = 0;
        idle_cycles = 0;
        send_gap    = 0;
        pop_gap     = 0;
        hold_left   = 0;
        hold_req    = 1'b0;
        push_taken  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every delta-of-delta class, window reuse and renewal
        queue_sample(64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
        queue_sample(64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        queue_sample(64'h7fff_ffff_ffff_ffff, 64'h0000_0000_0000_0000);
        queue_sample(64'h7fff_ffff_ffff_ffff, 64'h0000_0000_0000_0001);
        queue_sample(64'h8000_0000_0000_2000, 64'h8000_0000_0000_0001);
        queue_sample(64'h8000_0000_0000_4001, 64'h8000_0000_0000_0000);
        queue_sample(64'h8000_0000_0000_6002, 64'h0000_0000_0001_0000);
        queue_sample(64'h8000_0000_0001_6003, 64'h0000_0000_0003_0000);
        queue_sample(64'h8000_0000_0003_6004, 64'h0000_0000_0002_0000);
        queue_sample(64'h8000_0000_000b_6005, 64'h4000_0000_0000_0000);
        queue_sample(64'h8000_0000_0013_6006, 64'h4000_0000_0000_0000);
        queue_sample(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
        queue_sample(64'h0000_0000_0000_0005, 64'hffff_ffff_ffff_ffff);
        queue_sample(64'h0000_0000_0000_000a, 64'hffff_ffff_ffff_fffe);
        wait_drained();

        // resumed chunk with a live window
        write_reg(tsx_pkg::RegResumeCount, 64'd5);
        write_reg(tsx_pkg::RegResumeTime, 64'h0000_0123_4567_0000);
        write_reg(tsx_pkg::RegResumeBits, 64'h4059_0000_0000_0000);
        write_reg(tsx_pkg::RegResumeDelta, 64'd1000);
        write_reg(tsx_pkg::RegResumeLeading, 64'd10);
        write_reg(tsx_pkg::RegResumeTrailing, 64'd3);
        queue_series(150);
        wait_drained();

        // count about to wrap, window that can never match, long receiver hold
        write_reg(tsx_pkg::RegResumeCount, 64'hffff);
        write_reg(tsx_pkg::RegResumeLeading, 64'd40);
        write_reg(tsx_pkg::RegResumeTrailing, 64'd63);
        write_reg(tsx_pkg::RegResumeTime, 64'h7fff_ffff_ffff_ffff);
        write_reg(tsx_pkg::RegResumeBits, 64'h0);
        write_reg(tsx_pkg::RegResumeDelta, 64'hffff_ffff_ffff_ffff);
        write_reg(RegSpare, 64'hffff_ffff_ffff_ffff);
        hold_req = 1'b1;
        queue_series(150);
        wait_drained();

        // fresh chunk with no window
        write_reg(tsx_pkg::RegResumeCount, 64'd0);
        write_reg(tsx_pkg::RegResumeLeading, 64'hff);
        write_reg(tsx_pkg::RegResumeTrailing, 64'd0);
        write_reg(tsx_pkg::RegResumeTime, 64'h8000_0000_0000_0000);
        queue_series(150);
        wait_drained();

        if (n_errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
